// ===== rtl/bfmc_pkg.sv =====
// Shared types, codes and constants of the buffer frame manager.
`default_nettype none
package bfmc_pkg;
   localparam int NumFramesDef = 16;
   localparam int FileBitsDef  = 8;
   localparam int PageBitsDef  = 20;
   localparam logic [7:0] PinMax = 8'd255;

   typedef enum logic [2:0] {
      KIND_READ    = 3'd0,
      KIND_UNPIN   = 3'd1,
      KIND_ALLOC   = 3'd2,
      KIND_DISPOSE = 3'd3,
      KIND_FLUSH   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EXCEEDED = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_NOTPIN   = 3'd3,
      ST_PINNED   = 3'd4,
      ST_BADBUF   = 3'd5,
      ST_DUP      = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_FETCH = 2'd2
   } action_type;
endpackage
`default_nettype wire

// ===== rtl/buffer_frame_manager_clock.sv =====
// Top level of the buffer frame manager with clock replacement.
`default_nettype none
// A request is taken at a clock edge where start is high and busy is low. Busy then stays
// high until the request's final result (last = 1) has been shown, so requests run one at a
// time. Results are one-cycle strobes on rsp_valid and cannot be stalled: the receiver must
// take each one in the cycle it appears. Frame descriptors live in a memory with registered
// read data, and a valid bit per frame is kept in flip-flops, so each frame visit takes a
// read state and a check state. Every request first scans all frames for its tag and then
// decides in S_DO. A hit, an unpin, a dispose or an unknown kind ends there. A miss then
// steps the clock hand, a read and a check per step, over at most two full passes, and
// closes with a final result from S_FIN, or with ST_EXCEEDED when no victim is found. A
// flush visits every frame once, unless it stops at a pinned page of its file.
module buffer_frame_manager_clock
   import bfmc_pkg::*;
#(
   parameter int NUM_FRAMES = NumFramesDef,
   parameter int FILE_BITS  = FileBitsDef,
   parameter int PAGE_BITS  = PageBitsDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_file_id,
   input  wire logic [19:0] req_page_number,
   input  wire logic        req_mark_dirty,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [1:0]       rsp_action,
   output logic [3:0]       rsp_frame,
   output logic [7:0]       rsp_io_file,
   output logic [19:0]      rsp_io_page,
   output logic             rsp_last
);
   localparam int AW = $clog2(NUM_FRAMES);
   localparam int CW = $clog2(NUM_FRAMES + 1);
   localparam int SW = $clog2(2 * NUM_FRAMES);
   // Descriptor word: dirty, referenced, pins, file tag, page tag.
   localparam int DW = 2 + 8 + FILE_BITS + PAGE_BITS;
   localparam logic [AW-1:0] LastIdx = AW'(NUM_FRAMES - 1);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_SRD    = 9'b000000010,
      S_SCHK   = 9'b000000100,
      S_DO     = 9'b000001000,
      S_WRD    = 9'b000010000,
      S_WCHK   = 9'b000100000,
      S_FRD    = 9'b001000000,
      S_FCHK   = 9'b010000000,
      S_FIN    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [NUM_FRAMES-1:0] valid_ff, valid_in;
   logic [AW-1:0] hand_ff, hand_in, idx_ff, idx_in;
   logic [SW-1:0] step_ff, step_in;
   logic [CW-1:0] pinned_ff, pinned_in;
   logic hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic [2:0] kind_ff, kind_in;
   logic [FILE_BITS-1:0] file_ff, file_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic md_ff, md_in;
   logic [DW-1:0] hit_desc_ff, hit_desc_in;

   logic rv_ff, rv_in, rl_ff, rl_in;
   logic [2:0] rs_ff, rs_in;
   logic [1:0] ra_ff, ra_in;
   logic [3:0] rf_ff, rf_in;
   logic [7:0] rif_ff, rif_in;
   logic [19:0] rip_ff, rip_in;

   logic [AW-1:0] rd_addr, wr_addr;
   logic [DW-1:0] rd_data, wr_data;
   logic wr_en;

   bfmc_desc_mem #(.NUM_FRAMES(NUM_FRAMES), .WIDTH(DW)) u_mem (
      .clock(clock), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   logic d_dirty, d_ref;
   logic [7:0] d_pins;
   logic [FILE_BITS-1:0] d_file;
   logic [PAGE_BITS-1:0] d_page;
   assign {d_dirty, d_ref, d_pins, d_file, d_page} = rd_data;

   logic h_dirty, h_ref;
   logic [7:0] h_pins;
   logic [FILE_BITS-1:0] h_file;
   logic [PAGE_BITS-1:0] h_page;
   assign {h_dirty, h_ref, h_pins, h_file, h_page} = hit_desc_ff;

   logic [AW-1:0] hand_next;
   assign hand_next = (hand_ff == LastIdx) ? '0 : hand_ff + 1'b1;

   function automatic logic [3:0] fr4(input logic [AW-1:0] i);
      return 4'(i);
   endfunction

   always_comb begin
      state_in = state_ff; valid_in = valid_ff; hand_in = hand_ff; idx_in = idx_ff;
      step_in = step_ff; pinned_in = pinned_ff; hit_in = hit_ff;
      hit_idx_in = hit_idx_ff; kind_in = kind_ff; file_in = file_ff; page_in = page_ff;
      md_in = md_ff; hit_desc_in = hit_desc_ff;
      rv_in = 1'b0; rl_in = 1'b1; rs_in = ST_OK; ra_in = ACT_NONE; rf_in = '0;
      rif_in = '0; rip_in = '0;
      rd_addr = idx_ff; wr_en = 1'b0; wr_addr = idx_ff; wr_data = rd_data;
      case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               kind_in = req_kind; file_in = FILE_BITS'(req_file_id);
               page_in = PAGE_BITS'(req_page_number);
               md_in = req_mark_dirty; hit_in = 1'b0; idx_in = '0;
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            rd_addr = idx_ff; state_in = S_SCHK;
         end
         S_SCHK: begin
            // Lowest matching index wins.
            if (!hit_ff && valid_ff[idx_ff] && d_file == file_ff && d_page == page_ff) begin
               hit_in = 1'b1; hit_idx_in = idx_ff; hit_desc_in = rd_data;
            end
            if (idx_ff == LastIdx) begin
               state_in = S_DO;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = S_SRD;
            end
         end
         S_DO: begin
            state_in = S_IDLE; rv_in = 1'b1; wr_addr = hit_idx_ff;
            case (kind_ff)
               KIND_READ, KIND_ALLOC: begin
                  if (hit_ff) begin
                     if (kind_ff == KIND_READ) begin
                        wr_en = 1'b1;
                        wr_data = {h_dirty, 1'b1, (h_pins < PinMax) ? h_pins + 8'd1 : h_pins,
                                   h_file, h_page};
                        rf_in = fr4(hit_idx_ff);
                     end else begin
                        rs_in = ST_DUP; rf_in = fr4(hit_idx_ff);
                     end
                  end else begin
                     rv_in = 1'b0; step_in = '0; pinned_in = '0;
                     hand_in = hand_next; state_in = S_WRD;
                  end
               end
               KIND_UNPIN: begin
                  if (!hit_ff) rs_in = ST_NOTFOUND;
                  else if (h_pins == 8'd0) begin
                     rs_in = ST_NOTPIN; rf_in = fr4(hit_idx_ff);
                  end else begin
                     wr_en = 1'b1;
                     wr_data = {h_dirty | md_ff, h_ref, h_pins - 8'd1, h_file, h_page};
                     rf_in = fr4(hit_idx_ff);
                  end
               end
               KIND_DISPOSE: begin
                  if (hit_ff) begin
                     valid_in[hit_idx_ff] = 1'b0; rf_in = fr4(hit_idx_ff);
                  end
               end
               KIND_FLUSH: begin
                  rv_in = 1'b0; idx_in = '0; state_in = S_FRD;
               end
               default: ;
            endcase
         end
         S_WRD: begin
            rd_addr = hand_ff; state_in = S_WCHK;
         end
         S_WCHK: begin
            wr_addr = hand_ff;
            if (!valid_ff[hand_ff] || (!d_ref && d_pins == 8'd0)) begin
               // Victim: a dirty page goes out now, the final result follows next cycle.
               if (valid_ff[hand_ff] && d_dirty) begin
                  rv_in = 1'b1; rl_in = 1'b0; ra_in = ACT_WRITE; rf_in = fr4(hand_ff);
                  rif_in = 8'(d_file); rip_in = 20'(d_page);
               end
               wr_en = 1'b1; wr_data = {1'b0, 1'b1, 8'd1, file_ff, page_ff};
               valid_in[hand_ff] = 1'b1;
               state_in = S_FIN;
            end else begin
               logic [CW-1:0] pc;
               pc = pinned_ff;
               if (step_ff == SW'(NUM_FRAMES)) pc = '0;
               if (d_pins != 8'd0) pc = pc + 1'b1;
               if (d_ref) begin
                  wr_en = 1'b1; wr_data = {d_dirty, 1'b0, d_pins, d_file, d_page};
               end
               pinned_in = pc;
               if (pc == CW'(NUM_FRAMES) || step_ff == SW'(2 * NUM_FRAMES - 1)) begin
                  rv_in = 1'b1; rs_in = ST_EXCEEDED; state_in = S_IDLE;
               end else begin
                  step_in = step_ff + 1'b1; hand_in = hand_next; state_in = S_WRD;
               end
            end
         end
         S_FRD: begin
            rd_addr = idx_ff; state_in = S_FCHK;
         end
         S_FCHK: begin
            state_in = S_FRD;
            if (valid_ff[idx_ff] && d_file == file_ff) begin
               if (d_pins != 8'd0) begin
                  rv_in = 1'b1; rs_in = ST_PINNED; rf_in = fr4(idx_ff); state_in = S_IDLE;
               end else begin
                  if (d_dirty) begin
                     rv_in = 1'b1; rl_in = 1'b0; ra_in = ACT_WRITE; rf_in = fr4(idx_ff);
                     rif_in = 8'(d_file); rip_in = 20'(d_page);
                  end
                  valid_in[idx_ff] = 1'b0;
               end
            end
            if (state_in == S_FRD) begin
               if (idx_ff == LastIdx) state_in = S_FIN;
               else idx_in = idx_ff + 1'b1;
            end
         end
         S_FIN: begin
            // Closing result of a miss or a flush; the hand still points at the new frame.
            rv_in = 1'b1; state_in = S_IDLE;
            if (kind_ff == KIND_READ) begin
               ra_in = ACT_FETCH; rf_in = fr4(hand_ff);
               rif_in = 8'(file_ff); rip_in = 20'(page_ff);
            end else if (kind_ff == KIND_ALLOC) begin
               rf_in = fr4(hand_ff);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; hand_ff <= LastIdx; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; hand_ff <= hand_in; rv_ff <= rv_in;
      end
      idx_ff <= idx_in; step_ff <= step_in; pinned_ff <= pinned_in; hit_ff <= hit_in;
      hit_idx_ff <= hit_idx_in; kind_ff <= kind_in; file_ff <= file_in;
      page_ff <= page_in; md_ff <= md_in; hit_desc_ff <= hit_desc_in;
      rl_ff <= rl_in; rs_ff <= rs_in; ra_ff <= ra_in; rf_ff <= rf_in;
      rif_ff <= rif_in; rip_ff <= rip_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_action = ra_ff;
   assign rsp_frame = rf_ff;
   assign rsp_io_file = rif_ff;
   assign rsp_io_page = rip_ff;
   assign rsp_last = rl_ff;

   assign busy = (state_ff != S_IDLE) || rv_ff;

   a_idle_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> busy) else $error("busy low while working");
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> busy) else $error("request ended without a final result");
   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid) else $error("result after the final one");
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_SRD)) else $error("request not taken");
endmodule
`default_nettype wire

// ===== rtl/bfmc_desc_mem.sv =====
// Frame descriptor memory: one read port and one write port, registered read data.
`default_nettype none
module bfmc_desc_mem
   import bfmc_pkg::*;
#(
   parameter int NUM_FRAMES = NumFramesDef,
   parameter int WIDTH      = 40,
   localparam int AW = $clog2(NUM_FRAMES)
) (
   input  wire logic             clock,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data
);
   logic [WIDTH-1:0] mem [NUM_FRAMES];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== bench/tb_buffer_frame_manager_clock.sv =====
// Testbench for the buffer frame manager: directed and random requests checked by a scoreboard.
`timescale 1ns / 1ps
module tb_buffer_frame_manager_clock
   import bfmc_pkg::*;
();

   localparam int Frames = 16;
   localparam int WatchLimit = 5000;

   typedef struct {
      logic [2:0]  status;
      logic [1:0]  action;
      logic [3:0]  frame;
      logic [7:0]  io_file;
      logic [19:0] io_page;
      logic        last;
   } frame_result_type;

   class frame_scoreboard;
      bit          valid[Frames];
      bit          dirty[Frames];
      bit          referenced[Frames];
      logic [7:0]  pins[Frames];
      logic [7:0]  file_tag[Frames];
      logic [19:0] page_tag[Frames];
      int          hand;
      frame_result_type expected_results[$];
      int          errors;
      int          requests;
      int          results;
      int          writebacks;
      int          exceeded;

      function void reset_state();
         for (int i = 0; i < Frames; i++) clear_frame(i);
         hand = Frames - 1;
         expected_results.delete();
      endfunction

      function void clear_frame(int i);
         valid[i] = 1'b0;
         dirty[i] = 1'b0;
         referenced[i] = 1'b0;
         pins[i] = '0;
         file_tag[i] = '0;
         page_tag[i] = '0;
      endfunction

      function void set_frame(int i, logic [7:0] f, logic [19:0] p);
         valid[i] = 1'b1;
         dirty[i] = 1'b0;
         referenced[i] = 1'b1;
         pins[i] = 8'd1;
         file_tag[i] = f;
         page_tag[i] = p;
      endfunction

      function void push(logic [2:0] st, logic [1:0] act, int fr, logic [7:0] f,
                         logic [19:0] p, logic lst);
         frame_result_type r;
         r.status = st;
         r.action = act;
         r.frame = fr[3:0];
         r.io_file = f;
         r.io_page = p;
         r.last = lst;
         expected_results.push_back(r);
      endfunction

      function int lookup(logic [7:0] f, logic [19:0] p);
         for (int i = 0; i < Frames; i++)
            if (valid[i] && file_tag[i] == f && page_tag[i] == p) return i;
         return -1;
      endfunction

      // Clock sweep; gives the victim frame or -1 when a whole pass is pinned.
      function int sweep_victim();
         int pinned;
         int h;
         pinned = 0;
         for (int step = 0; step < 2 * Frames; step++) begin
            if (step % Frames == 0) pinned = 0;
            hand = (hand + 1) % Frames;
            h = hand;
            if (!valid[h]) return h;
            if (referenced[h]) begin
               referenced[h] = 1'b0;
               if (pins[h] > 0) pinned++;
            end else if (pins[h] > 0) begin
               pinned++;
            end else begin
               if (dirty[h]) push(ST_OK, ACT_WRITE, h, file_tag[h], page_tag[h], 1'b0);
               clear_frame(h);
               return h;
            end
            if (pinned == Frames) return -1;
         end
         return -1;
      endfunction

      function void note_request(logic [2:0] kind, logic [7:0] f, logic [19:0] p, logic md);
         int hit;
         int fr;
         bit stopped;
         requests++;
         hit = lookup(f, p);
         if (kind == KIND_READ || kind == KIND_ALLOC) begin
            if (hit >= 0 && kind == KIND_READ) begin
               if (pins[hit] != PinMax) pins[hit]++;
               referenced[hit] = 1'b1;
               push(ST_OK, ACT_NONE, hit, '0, '0, 1'b1);
            end else if (hit >= 0) begin
               push(ST_DUP, ACT_NONE, hit, '0, '0, 1'b1);
            end else begin
               fr = sweep_victim();
               if (fr < 0) begin
                  exceeded++;
                  push(ST_EXCEEDED, ACT_NONE, 0, '0, '0, 1'b1);
               end else begin
                  set_frame(fr, f, p);
                  if (kind == KIND_READ) push(ST_OK, ACT_FETCH, fr, f, p, 1'b1);
                  else push(ST_OK, ACT_NONE, fr, '0, '0, 1'b1);
               end
            end
         end else if (kind == KIND_UNPIN) begin
            if (hit < 0) push(ST_NOTFOUND, ACT_NONE, 0, '0, '0, 1'b1);
            else if (pins[hit] == 0) push(ST_NOTPIN, ACT_NONE, hit, '0, '0, 1'b1);
            else begin
               pins[hit]--;
               if (md) dirty[hit] = 1'b1;
               push(ST_OK, ACT_NONE, hit, '0, '0, 1'b1);
            end
         end else if (kind == KIND_DISPOSE) begin
            if (hit >= 0) clear_frame(hit);
            push(ST_OK, ACT_NONE, (hit >= 0) ? hit : 0, '0, '0, 1'b1);
         end else if (kind == KIND_FLUSH) begin
            stopped = 1'b0;
            for (int i = 0; i < Frames && !stopped; i++) begin
               if (valid[i] && file_tag[i] == f) begin
                  if (pins[i] > 0) begin
                     push(ST_PINNED, ACT_NONE, i, '0, '0, 1'b1);
                     stopped = 1'b1;
                  end else begin
                     if (dirty[i]) push(ST_OK, ACT_WRITE, i, file_tag[i], page_tag[i], 1'b0);
                     clear_frame(i);
                  end
               end
            end
            if (!stopped) push(ST_OK, ACT_NONE, 0, '0, '0, 1'b1);
         end else begin
            push(ST_OK, ACT_NONE, 0, '0, '0, 1'b1);
         end
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (exp !== act) begin
            errors++;
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp, act);
         end
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type exp;
         results++;
         if (got.action == ACT_WRITE) writebacks++;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual status %0d frame %0d",
                     $time, got.status, got.frame);
            return;
         end
         exp = expected_results.pop_front();
         compare_field("status", 32'(exp.status), 32'(got.status));
         compare_field("action", 32'(exp.action), 32'(got.action));
         compare_field("frame", 32'(exp.frame), 32'(got.frame));
         compare_field("io_file", 32'(exp.io_file), 32'(got.io_file));
         compare_field("io_page", 32'(exp.io_page), 32'(got.io_page));
         compare_field("last", 32'(exp.last), 32'(got.last));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_kind;
   logic [7:0]  req_file_id;
   logic [19:0] req_page_number;
   logic        req_mark_dirty;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_action;
   logic [3:0]  rsp_frame;
   logic [7:0]  rsp_io_file;
   logic [19:0] rsp_io_page;
   logic        rsp_last;

   frame_scoreboard board;
   bit  steady_drive;
   int  quiet_cycles;

   buffer_frame_manager_clock i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_file_id(req_file_id),
      .req_page_number(req_page_number),
      .req_mark_dirty(req_mark_dirty),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_action(rsp_action),
      .rsp_frame(rsp_frame),
      .rsp_io_file(rsp_io_file),
      .rsp_io_page(rsp_io_page),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Results are checked before a request taken at the same edge is predicted.
   always @(posedge clock) begin
      frame_result_type got;
      bit progress;
      if (!reset) begin
         progress = 1'b0;
         if (rsp_valid) begin
            got.status = rsp_status;
            got.action = rsp_action;
            got.frame = rsp_frame;
            got.io_file = rsp_io_file;
            got.io_page = rsp_io_page;
            got.last = rsp_last;
            board.check_result(got);
            progress = 1'b1;
         end
         if (start && !busy) begin
            board.note_request(req_kind, req_file_id, req_page_number, req_mark_dirty);
            progress = 1'b1;
         end
         if (quiet_cycles >= WatchLimit) begin
            $display("watchdog: no progress for %0d cycles", WatchLimit);
            $display("FAIL");
            $finish;
         end
         quiet_cycles <= progress ? 0 : quiet_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(logic [2:0] kind, logic [7:0] f, logic [19:0] p, logic md);
      bit taken;
      while (!steady_drive && $urandom_range(99) < 32) begin
         start = 0;
         @(negedge clock);
      end
      start = 1;
      req_kind = kind;
      req_file_id = f;
      req_page_number = p;
      req_mark_dirty = md;
      do begin
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      @(negedge clock);
   endtask

   task automatic send_random();
      int pick;
      logic [2:0]  kind;
      logic [7:0]  f;
      logic [19:0] p;
      pick = $urandom_range(99);
      if (pick < 35) kind = KIND_READ;
      else if (pick < 65) kind = KIND_UNPIN;
      else if (pick < 77) kind = KIND_ALLOC;
      else if (pick < 88) kind = KIND_DISPOSE;
      else if (pick < 96) kind = KIND_FLUSH;
      else kind = 3'($urandom_range(7, 5));
      // A small tag pool keeps hits, pins and evictions frequent.
      if ($urandom_range(9) == 0) begin
         f = 8'($urandom);
         p = 20'($urandom);
      end else begin
         f = 8'($urandom_range(3));
         p = 20'($urandom_range(7));
         if ($urandom_range(7) == 0) begin
            f = ~f;
            p = ~p;
         end
      end
      send_request(kind, f, p, 1'($urandom));
   endtask

   initial begin
      board = new();
      board.reset_state();
      reset = 1;
      start = 0;
      req_kind = KIND_READ;
      req_file_id = 0;
      req_page_number = 0;
      req_mark_dirty = 0;
      steady_drive = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part: extremes, every operation and the status codes the design returns.
      send_request(KIND_READ, 8'hFF, 20'hFFFFF, 1'b0);
      send_request(KIND_READ, 8'hFF, 20'hFFFFF, 1'b0);
      send_request(KIND_UNPIN, 8'hFF, 20'hFFFFF, 1'b1);
      send_request(KIND_UNPIN, 8'hFF, 20'hFFFFF, 1'b1);
      send_request(KIND_UNPIN, 8'hFF, 20'hFFFFF, 1'b0);
      send_request(KIND_UNPIN, 8'h00, 20'h00000, 1'b0);
      send_request(KIND_ALLOC, 8'hFF, 20'hFFFFF, 1'b0);
      send_request(KIND_ALLOC, 8'h00, 20'h00000, 1'b0);
      send_request(KIND_DISPOSE, 8'h00, 20'h00000, 1'b0);
      send_request(KIND_DISPOSE, 8'h00, 20'h00000, 1'b0);
      send_request(KIND_FLUSH, 8'hFF, 20'h0, 1'b0);
      send_request(3'd7, 8'h5A, 20'hA5A5A, 1'b1);
      // Pin every frame, then a miss finds no victim.
      for (int i = 0; i < Frames; i++) send_request(KIND_READ, 8'h01, 20'(i), 1'b0);
      send_request(KIND_READ, 8'h02, 20'h0, 1'b0);
      send_request(KIND_ALLOC, 8'h02, 20'h1, 1'b0);
      send_request(KIND_FLUSH, 8'h01, 20'h0, 1'b0);

      // Drive one pin count into saturation and back down.
      steady_drive = 1;
      repeat (256) send_request(KIND_READ, 8'h01, 20'h3, 1'b0);
      repeat (2) send_request(KIND_UNPIN, 8'h01, 20'h3, 1'b1);
      for (int i = 0; i < Frames; i++) send_request(KIND_UNPIN, 8'h01, 20'(i), 1'($urandom));
      send_request(KIND_DISPOSE, 8'h01, 20'h3, 1'b0);
      send_request(KIND_FLUSH, 8'h01, 20'h0, 1'b0);
      steady_drive = 0;

      for (int n = 0; n < 115; n++) begin
         steady_drive = (n >= 30 && n < 75);
         send_random();
      end
      start = 0;

      while (board.expected_results.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("Covered %0d requests and %0d results, %0d write-backs, %0d full-pool misses.",
               board.requests, board.results, board.writebacks, board.exceeded);
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches found.", board.errors);
         $display("FAIL");
      end
      $finish;
   end
endmodule
